// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_FILL   = 4;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // widths of the item fields
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CHAR_W = 8;
  localparam int PUT_W  = $clog2(TAB_FILL + 1);

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CH_BEL = 8'h07;
  localparam char_t CH_BS  = 8'h08;
  localparam char_t CH_TAB = 8'h09;
  localparam char_t CH_LF  = 8'h0A;
  localparam char_t CH_VT  = 8'h0B;
  localparam char_t CH_FF  = 8'h0C;
  localparam char_t CH_CR  = 8'h0D;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

endpackage

// ----- rtl/tcw_if.sv -----
interface tcw_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [tcw_pkg::CHAR_W-1:0]  char_code;
  logic [tcw_pkg::ADDR_W-1:0]  cell_index;

  modport source (output valid, mode, char_code, cell_index, input ready);
  modport sink   (input valid, mode, char_code, cell_index, output ready);
endinterface

interface tcw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::COL_W-1:0]   cursor_column;
  logic [tcw_pkg::ROW_W-1:0]   cursor_row;
  logic [tcw_pkg::ADDR_W-1:0]  cursor_position;
  logic [tcw_pkg::CHAR_W-1:0]  read_char;

  modport source (output valid, cursor_column, cursor_row, cursor_position, read_char,
                  input ready);
  modport sink   (input valid, cursor_column, cursor_row, cursor_position, read_char,
                  output ready);
endinterface

// ----- rtl/tcw_cell_ram.sv -----
module tcw_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/text_console_character_writer_top.sv -----
// Text console: cursor plus an 80 x 25 store of character codes.
// in_ch carries one item: mode 0 writes char_code through the console
// (control codes included), mode 1 reads the cell at cell_index.
// out_ch returns one item per input item: cursor column, row and linear
// position after the item, and the cell read (zero on a write).
// Both channels use valid/ready; an item moves when both are high.
// Bell, backspace, carriage return, newline and vertical tab without
// scrolling go straight to S_OUT, which loads the output register; a read
// passes through S_READ first, an ordinary character through S_PUT, and a
// tab through S_PUT for TAB_FILL zero cells. A scroll walks the store
// through its single write port, one cell per cycle, for the row copy and
// last-row clear. Form feed clears all 2000 cells, one per cycle.
// The next item is taken the cycle after a result is loaded, at the earliest.
// After reset the same clear of all 2000 cells runs before the first item is taken.
// in_ch.ready is high only while no item is in work. A finished result
// waits in the output register; one further item is taken meanwhile, and
// its result holds in the engine until the register empties.
module text_console_character_writer_top (
  input logic     clk,
  input logic     rst_n,
  tcw_in_if.sink  in_ch,
  tcw_out_if.source out_ch
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PUT,
    S_SCROLL,
    S_CLEAR,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_OUT,
    RET_PUT
  } ret_t;

  state_t            state_r, state_nxt;
  ret_t              ret_r, ret_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [PUT_W-1:0]  put_cnt_r, put_cnt_nxt;
  char_t             put_char_r, put_char_nxt;
  logic              rd_oob_r, rd_oob_nxt;
  char_t             rd_char_r, rd_char_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [ADDR_W-1:0] out_pos_r, out_pos_nxt;
  char_t             out_char_r, out_char_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  char_t             mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  char_t             mem_rdata;

  logic [ADDR_W-1:0] cur_pos;
  logic              last_row;
  logic              last_col;
  logic              in_acc;

  assign cur_pos  = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign last_row = (row_r >= ROW_W'(ROWS - 1));
  assign last_col = (col_r >= COL_W'(COLUMNS - 1));
  assign in_acc   = in_ch.valid && in_ch.ready;

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_column   = out_col_r;
  assign out_ch.cursor_row      = out_row_r;
  assign out_ch.cursor_position = out_pos_r;
  assign out_ch.read_char       = out_char_r;

  tcw_cell_ram #(
    .DEPTH  (CELL_COUNT),
    .DATA_W (CHAR_W),
    .ADDR_W (ADDR_W)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    mem_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.cell_index < ADDR_W'(CELL_COUNT)) begin
          mem_raddr = in_ch.cell_index;
        end
      end
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SCROLL: begin
        mem_we    = pend_r;
        mem_waddr = pend_addr_r;
        mem_wdata = mem_rdata;
        if (src_r < ADDR_W'(CELL_COUNT)) begin
          mem_raddr = src_r;
        end
      end
      S_PUT: begin
        if (put_cnt_r != '0 && !(last_row && last_col)) begin
          mem_we    = 1'b1;
          mem_waddr = cur_pos;
          mem_wdata = put_char_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    clr_nxt       = clr_r;
    src_nxt       = src_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    put_cnt_nxt   = put_cnt_r;
    put_char_nxt  = put_char_r;
    rd_oob_nxt    = rd_oob_r;
    rd_char_nxt   = rd_char_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_pos_nxt   = out_pos_r;
    out_char_nxt  = out_char_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rd_char_nxt = '0;
          ret_nxt     = RET_OUT;
          state_nxt   = S_OUT;
          if (in_ch.mode == MODE_READ) begin
            rd_oob_nxt = (in_ch.cell_index >= ADDR_W'(CELL_COUNT));
            state_nxt  = S_READ;
          end else begin
            unique case (in_ch.char_code) inside
              CH_BEL: begin
              end
              CH_BS: begin
                if (col_r == '0) begin
                  if (row_r != '0) begin
                    row_nxt = row_r - ROW_W'(1);
                    col_nxt = COL_W'(COLUMNS - 1);
                  end
                end else begin
                  col_nxt = col_r - COL_W'(1);
                end
              end
              CH_FF: begin
                col_nxt   = '0;
                row_nxt   = '0;
                clr_nxt   = '0;
                state_nxt = S_CLEAR;
              end
              CH_LF, CH_VT: begin
                if (in_ch.char_code == CH_LF) begin
                  col_nxt = '0;
                end
                if (last_row) begin
                  src_nxt   = ADDR_W'(COLUMNS);
                  state_nxt = S_SCROLL;
                end else begin
                  row_nxt = row_r + ROW_W'(1);
                end
              end
              CH_CR: begin
                col_nxt = '0;
              end
              CH_TAB: begin
                put_cnt_nxt  = PUT_W'(TAB_FILL);
                put_char_nxt = '0;
                ret_nxt      = RET_PUT;
                state_nxt    = S_PUT;
              end
              default: begin
                put_cnt_nxt  = PUT_W'(1);
                put_char_nxt = in_ch.char_code;
                ret_nxt      = RET_PUT;
                state_nxt    = S_PUT;
              end
            endcase
          end
        end
      end

      S_READ: begin
        rd_char_nxt = rd_oob_r ? char_t'(0) : mem_rdata;
        state_nxt   = S_OUT;
      end

      S_PUT: begin
        if (put_cnt_r == '0) begin
          state_nxt = S_OUT;
        end else if (last_row && last_col) begin
          // bottom-right corner: scroll first, then write at column 0
          col_nxt   = '0;
          src_nxt   = ADDR_W'(COLUMNS);
          state_nxt = S_SCROLL;
        end else begin
          put_cnt_nxt = put_cnt_r - PUT_W'(1);
          if (last_col) begin
            col_nxt = '0;
            if (!last_row) begin
              row_nxt = row_r + ROW_W'(1);
            end
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end

      S_SCROLL: begin
        // read one row ahead, write it back in the following cycle
        if (src_r < ADDR_W'(CELL_COUNT)) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = src_r - ADDR_W'(COLUMNS);
          src_nxt       = src_r + ADDR_W'(1);
        end else begin
          clr_nxt   = ADDR_W'(CELL_COUNT - COLUMNS);
          state_nxt = S_CLEAR;
        end
      end

      S_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(CELL_COUNT - 1)) begin
          unique case (ret_r)
            RET_PUT:  state_nxt = S_PUT;
            RET_OUT:  state_nxt = S_OUT;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          out_pos_nxt   = cur_pos;
          out_char_nxt  = rd_char_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ret_r       <= RET_IDLE;
      clr_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      clr_r       <= clr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    src_r       <= src_nxt;
    pend_addr_r <= pend_addr_nxt;
    put_cnt_r   <= put_cnt_nxt;
    put_char_r  <= put_char_nxt;
    rd_oob_r    <= rd_oob_nxt;
    rd_char_r   <= rd_char_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_pos_r   <= out_pos_nxt;
    out_char_r  <= out_char_nxt;
  end

endmodule

// ----- sim/tb_text_console_character_writer_top.sv -----
`timescale 1ns / 100ps

module tb_text_console_character_writer_top;
  import tcw_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] position;
    char_t             read_char;
  } cursor_report_t;

  typedef struct {
    logic              mode;
    char_t             code;
    logic [ADDR_W-1:0] index;
    int                reps;
    bit                typed;
    cursor_report_t    want;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 1300;
  // scroll and form feed each walk the whole store, so keep their count bounded
  localparam int SCROLL_BUDGET = 180;
  localparam cursor_report_t AT_HOME = '0;

  logic clk;
  logic rst_n;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();

  text_console_character_writer_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_t          screen_model [CELL_COUNT];
  int             cur_col;
  int             cur_row;
  cursor_report_t pending_reports [$];
  stim_row_t      stim_table [$];
  int             mismatches;
  int             scrolls_used;
  bit             quiet_stretch;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("text_console_character_writer_top test failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  task automatic scroll_screen();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen_model[i] = '0;
  endtask

  task automatic put_char(input char_t c);
    // last cell: scroll first, then write at column 0 of the last row
    if (cur_row >= ROWS - 1 && cur_col >= COLUMNS - 1) begin
      cur_col = 0;
      scroll_screen();
    end
    screen_model[cur_row * COLUMNS + cur_col] = c;
    if (cur_col >= COLUMNS - 1) begin
      cur_col = 0;
      if (cur_row < ROWS - 1) cur_row++;
    end else begin
      cur_col++;
    end
  endtask

  function automatic bit is_control(input char_t c);
    case (c) inside
      CH_BEL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // true when the item would make the block walk the whole store
  function automatic bit walks_store(input logic m, input char_t c);
    bit last_row;
    last_row = (cur_row >= ROWS - 1);
    if (m == MODE_READ) return 1'b0;
    if (c == CH_FF) return 1'b1;
    if (!last_row) return 1'b0;
    if (c == CH_LF || c == CH_VT) return 1'b1;
    if (c == CH_TAB) return cur_col >= COLUMNS - TAB_FILL;
    return !is_control(c) && cur_col >= COLUMNS - 1;
  endfunction

  task automatic predict_cursor(input logic m, input char_t c, input logic [ADDR_W-1:0] idx,
                                output cursor_report_t r);
    char_t rd;
    rd = '0;
    if (m == MODE_READ) begin
      if (idx < CELL_COUNT) rd = screen_model[idx];
    end else begin
      case (c)
        CH_BEL: ;
        CH_BS: begin
          if (cur_col == 0) begin
            if (cur_row != 0) begin
              cur_row--;
              cur_col = COLUMNS - 1;
            end
          end else begin
            cur_col--;
          end
        end
        CH_FF: begin
          foreach (screen_model[i]) screen_model[i] = '0;
          cur_col = 0;
          cur_row = 0;
        end
        CH_LF: begin
          cur_col = 0;
          if (cur_row >= ROWS - 1) scroll_screen();
          else cur_row++;
        end
        CH_CR: cur_col = 0;
        CH_TAB: for (int i = 0; i < TAB_FILL; i++) put_char('0);
        CH_VT: begin
          if (cur_row >= ROWS - 1) scroll_screen();
          else cur_row++;
        end
        default: put_char(c);
      endcase
    end
    r.column    = cur_col[COL_W-1:0];
    r.row       = cur_row[ROW_W-1:0];
    r.position  = ADDR_W'(cur_row * COLUMNS + cur_col);
    r.read_char = rd;
  endtask

  // ---------------------------------------------------------------- driving

  task automatic send_item(input logic m, input char_t c, input logic [ADDR_W-1:0] idx,
                           input bit typed, input cursor_report_t want);
    cursor_report_t r;
    while (!quiet_stretch && $urandom_range(0, 99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.char_code  <= c;
    in_ch.cell_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    if (walks_store(m, c)) scrolls_used++;
    predict_cursor(m, c, idx, r);
    if (typed) r = want;
    pending_reports.push_back(r);
  endtask

  task automatic add_row(input logic m, input char_t c, input logic [ADDR_W-1:0] idx,
                         input int reps, input bit typed, input cursor_report_t want);
    stim_row_t row;
    row.mode  = m;
    row.code  = c;
    row.index = idx;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  initial begin
    stim_row_t      row;
    logic           m;
    char_t          c;
    logic [ADDR_W-1:0] idx;
    int             sel;
    int             pos;
    int             back;

    mismatches    = 0;
    scrolls_used  = 0;
    quiet_stretch = 1'b0;
    cur_col       = 0;
    cur_row       = 0;
    foreach (screen_model[i]) screen_model[i] = '0;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_WRITE;
    in_ch.char_code  <= '0;
    in_ch.cell_index <= '0;

    // cleared store after reset, out-of-range read, top-left corner cases
    add_row(MODE_READ,  8'h00,  11'd0,    1, 1'b1, AT_HOME);
    add_row(MODE_READ,  8'hFF,  11'd2047, 1, 1'b1, AT_HOME);
    add_row(MODE_READ,  8'h00,  11'd1999, 1, 1'b1, AT_HOME);
    add_row(MODE_WRITE, CH_BEL, 11'd0,    1, 1'b1, AT_HOME);
    add_row(MODE_WRITE, CH_BS,  11'd2047, 1, 1'b1, AT_HOME);
    add_row(MODE_WRITE, 8'hFF,  11'd0,    1, 1'b1, '{7'd1, 5'd0, 11'd1, 8'h00});
    add_row(MODE_WRITE, 8'h00,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_TAB, 11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_BS,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_CR,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_READ,  8'h00,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_LF,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, 8'h41,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_VT,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_CR,  11'd0,    1, 1'b0, AT_HOME);
    // backspace from column 0 wraps to the previous row, then a char wraps forward
    add_row(MODE_WRITE, CH_BS,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, 8'h42,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_READ,  8'h00,  11'd2000, 1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_FF,  11'd0,    1, 1'b1, AT_HOME);
    // down to the last row, then the scrolling cases
    add_row(MODE_WRITE, CH_VT,  11'd0,    ROWS - 1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, 8'h43,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_LF,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_VT,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_BS,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, CH_VT,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_WRITE, 8'h7E,  11'd0,    1, 1'b0, AT_HOME);
    add_row(MODE_READ,  8'h00,  11'd1920, 1, 1'b0, AT_HOME);
    add_row(MODE_READ,  8'h00,  11'd1840, 1, 1'b0, AT_HOME);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[k]) begin
      row = stim_table[k];
      for (int n = 0; n < row.reps; n++)
        send_item(row.mode, row.code, row.index, row.typed, row.want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_stretch = (n >= 500 && n < 800);
      c   = char_t'($urandom_range(0, 255));
      idx = ADDR_W'($urandom_range(0, 2047));
      sel = $urandom_range(0, 99);
      if (sel < 33) begin
        m   = MODE_READ;
        sel = $urandom_range(0, 9);
        pos = cur_row * COLUMNS + cur_col;
        back = $urandom_range(0, 2 * COLUMNS);
        // mostly read back what was just written
        if (sel < 6) idx = ADDR_W'((pos >= back) ? pos - back : pos);
        else if (sel < 8) idx = ADDR_W'($urandom_range(0, CELL_COUNT - 1));
        else idx = ADDR_W'($urandom_range(CELL_COUNT, 2047));
      end else begin
        m   = MODE_WRITE;
        sel = $urandom_range(0, 99);
        if (sel < 2) c = CH_FF;
        else if (sel < 10) c = CH_LF;
        else if (sel < 14) c = CH_VT;
        else if (sel < 18) c = CH_BS;
        else if (sel < 21) c = CH_CR;
        else if (sel < 25) c = CH_TAB;
        else if (sel < 27) c = CH_BEL;
        else if (sel < 75) c = char_t'($urandom_range(8'h20, 8'h7E));
        if (walks_store(m, c) && scrolls_used >= SCROLL_BUDGET) m = MODE_READ;
      end
      send_item(m, c, idx, 1'b0, AT_HOME);
    end

    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_console_character_writer_top test passed");
    end else begin
      $display("text_console_character_writer_top test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_report();
    cursor_report_t want;
    if (pending_reports.size() == 0) begin
      report_mismatch("unexpected item, cursor_position", out_ch.cursor_position, -1);
    end else begin
      want = pending_reports.pop_front();
      if (out_ch.cursor_column !== want.column)
        report_mismatch("cursor_column", out_ch.cursor_column, want.column);
      if (out_ch.cursor_row !== want.row)
        report_mismatch("cursor_row", out_ch.cursor_row, want.row);
      if (out_ch.cursor_position !== want.position)
        report_mismatch("cursor_position", out_ch.cursor_position, want.position);
      if (out_ch.read_char !== want.read_char)
        report_mismatch("read_char", out_ch.read_char, want.read_char);
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_report();
      out_ch.ready <= quiet_stretch || ($urandom_range(0, 99) >= 18);
    end
  end

endmodule

// ----- filelist.f -----
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_cell_ram.sv
rtl/text_console_character_writer_top.sv
sim/tb_text_console_character_writer_top.sv
